// ===== design/rsn_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rsn_pkg;

  localparam int MAX_SPHERES = 16;
  localparam int FRAC_BITS   = 16;
  localparam int IDX_W       = $clog2(MAX_SPHERES);
  localparam int CNT_W       = IDX_W + 1;

  localparam logic [30:0] DIST_MAX = 31'h7fff_ffff;

  // sequencer codes, shared by the top level and every cell
  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_OC    = 4'd1;
  localparam logic [3:0] ST_MUL   = 4'd2;
  localparam logic [3:0] ST_DISC  = 4'd3;
  localparam logic [3:0] ST_SQRT  = 4'd4;
  localparam logic [3:0] ST_ROOT  = 4'd5;
  localparam logic [3:0] ST_CHAIN = 4'd6;
  localparam logic [3:0] ST_SHADE = 4'd7;
  localparam logic [3:0] ST_OUT   = 4'd8;

  typedef struct packed {
    logic        req_type;
    logic [3:0]  entry_index;
    logic [31:0] center_x;
    logic [31:0] center_y;
    logic [31:0] center_z;
    logic [30:0] sphere_radius;
    logic [31:0] origin_x;
    logic [31:0] origin_y;
    logic [31:0] origin_z;
    logic [31:0] dir_x;
    logic [31:0] dir_y;
    logic [31:0] dir_z;
  } rsn_in_t;

  typedef struct packed {
    logic        hit;
    logic [3:0]  hit_index;
    logic [30:0] hit_distance;
    logic [7:0]  intensity;
  } rsn_out_t;

  typedef struct packed {
    logic [31:0] ox;
    logic [31:0] oy;
    logic [31:0] oz;
    logic [31:0] dx;
    logic [31:0] dy;
    logic [31:0] dz;
  } rsn_ray_t;

  typedef struct packed {
    logic             valid;
    logic [34:0]      t;
    logic [IDX_W-1:0] idx;
    logic [31:0]      ocx;
    logic [31:0]      ocy;
    logic [31:0]      ocz;
  } rsn_best_t;

  typedef struct packed {
    logic             ld_en;
    logic [3:0]       state;
    logic [2:0]       msel;
    logic [CNT_W-1:0] count;
  } rsn_ctl_t;

  // saturate a 33-bit signed difference to 32 bits
  function automatic logic [31:0] sat33(input logic [32:0] d);
    logic [31:0] r;
    if (d[32] != d[31]) begin
      r = d[32] ? 32'h8000_0000 : 32'h7fff_ffff;
    end else begin
      r = d[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== design/rsn_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rsn_cell (
  input  logic                     clk,
  input  logic [rsn_pkg::IDX_W-1:0] cell_idx,
  input  rsn_pkg::rsn_ctl_t        ctl,
  input  rsn_pkg::rsn_in_t         req,
  input  rsn_pkg::rsn_ray_t        ray,
  input  rsn_pkg::rsn_best_t       prev,
  output rsn_pkg::rsn_best_t       best
);
  import rsn_pkg::*;

  logic [31:0] cx, cy, cz;
  logic [30:0] rad;
  logic [31:0] ocx, ocy, ocz, bsat;
  logic signed [49:0] bacc;
  logic [63:0] oc2, b2, r2, rem, res, bitv;
  logic hitc, own_hit;
  logic [34:0] own_t;

  logic signed [31:0] ma, mb;
  logic signed [63:0] prod, psh;
  logic [31:0] bsat_c;
  logic [63:0] bsum, trial;
  logic signed [34:0] nb, s35, t1, t2;
  logic active, take;

  // one shared multiplier, operands picked by the step code
  always_comb begin
    unique case (ctl.msel)
      3'd0: begin ma = $signed(ocx); mb = $signed(ray.dx); end
      3'd1: begin ma = $signed(ocy); mb = $signed(ray.dy); end
      3'd2: begin ma = $signed(ocz); mb = $signed(ray.dz); end
      3'd3: begin ma = $signed(ocx); mb = $signed(ocx); end
      3'd4: begin ma = $signed(ocy); mb = $signed(ocy); end
      3'd5: begin ma = $signed(ocz); mb = $signed(ocz); end
      3'd6: begin ma = $signed(bsat); mb = $signed(bsat); end
      3'd7: begin ma = $signed({1'b0, rad}); mb = $signed({1'b0, rad}); end
    endcase
  end

  assign prod = ma * mb;
  assign psh  = prod >>> FRAC_BITS;

  always_comb begin
    if ((&bacc[49:31]) || !(|bacc[49:31])) begin
      bsat_c = bacc[31:0];
    end else begin
      bsat_c = bacc[49] ? 32'h8000_0000 : 32'h7fff_ffff;
    end
  end

  assign bsum  = b2 + r2;
  assign trial = res + bitv;
  assign nb    = -$signed({{3{bsat[31]}}, bsat});
  assign s35   = $signed({3'b000, res[31:0]});
  assign t1    = nb - s35;
  assign t2    = nb + s35;

  assign active = {1'b0, cell_idx} < ctl.count;
  assign take   = active && own_hit && (!prev.valid || $signed(own_t) < $signed(prev.t));

  always_ff @(posedge clk) begin
    if (ctl.ld_en && req.entry_index == cell_idx) begin
      cx  <= req.center_x;
      cy  <= req.center_y;
      cz  <= req.center_z;
      rad <= req.sphere_radius;
    end
    unique case (ctl.state)
      ST_OC: begin
        ocx <= sat33({ray.ox[31], ray.ox} - {cx[31], cx});
        ocy <= sat33({ray.oy[31], ray.oy} - {cy[31], cy});
        ocz <= sat33({ray.oz[31], ray.oz} - {cz[31], cz});
      end
      ST_MUL: begin
        unique case (ctl.msel)
          3'd0: bacc <= psh[49:0];
          3'd1, 3'd2: bacc <= bacc + psh[49:0];
          3'd3: begin
            oc2  <= prod;
            bsat <= bsat_c;
          end
          3'd4, 3'd5: oc2 <= oc2 + prod;
          3'd6: b2 <= prod;
          3'd7: r2 <= prod;
        endcase
      end
      ST_DISC: begin
        hitc <= bsum > oc2;
        rem  <= bsum - oc2;
        res  <= '0;
        bitv <= 64'h4000_0000_0000_0000;
      end
      ST_SQRT: begin
        if (rem >= trial) begin
          rem <= rem - trial;
          res <= (res >> 1) + bitv;
        end else begin
          res <= res >> 1;
        end
        bitv <= bitv >> 2;
      end
      ST_ROOT: begin
        own_hit <= hitc && (!t1[34] || !t2[34]);
        own_t   <= t1[34] ? t2 : t1;
      end
      ST_CHAIN: begin
        if (take) begin
          best.valid <= 1'b1;
          best.t     <= own_t;
          best.idx   <= cell_idx;
          best.ocx   <= ocx;
          best.ocy   <= ocy;
          best.ocz   <= ocz;
        end else begin
          best <= prev;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== design/rsn_shade.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rsn_shade (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  rsn_pkg::rsn_best_t best,
  input  rsn_pkg::rsn_ray_t  ray,
  input  logic [7:0]         bg_level,
  output logic               done,
  output rsn_pkg::rsn_out_t  res
);
  import rsn_pkg::*;

  localparam logic [2:0] SH_IDLE = 3'd0;
  localparam logic [2:0] SH_NMUL = 3'd1;
  localparam logic [2:0] SH_NORM = 3'd2;
  localparam logic [2:0] SH_SUM  = 3'd3;
  localparam logic [2:0] SH_SQ   = 3'd4;
  localparam logic [2:0] SH_V    = 3'd5;
  localparam logic [2:0] SH_DONE = 3'd6;

  logic [2:0] state;
  logic [2:0] cnt;
  logic [1:0] sub;

  logic        hit_r;
  logic [IDX_W-1:0] idx_r;
  logic [30:0] hit_dist;
  logic [7:0]  lvl;
  logic [31:0] ocq [3];
  logic [47:0] nmag [3];
  logic        nneg [3];
  logic [41:0] len2;
  logic [21:0] spos;
  logic [43:0] ss, lhs;
  logic [59:0] rhs, vprod;
  logic [15:0] vsq;

  logic signed [31:0] dsel;
  logic [31:0] osel;
  logic signed [63:0] dprod, dsh;
  logic signed [48:0] nsum;
  logic signed [22:0] rs [3];
  logic signed [22:0] ssum;
  logic [7:0] vt;

  always_comb begin
    unique case (cnt[1:0])
      2'd0: begin dsel = $signed(ray.dx); osel = ocq[0]; end
      2'd1: begin dsel = $signed(ray.dy); osel = ocq[1]; end
      2'd2: begin dsel = $signed(ray.dz); osel = ocq[2]; end
      default: begin dsel = '0; osel = '0; end
    endcase
  end

  assign dprod = dsel * $signed({1'b0, hit_dist});
  assign dsh   = dprod >>> FRAC_BITS;
  assign nsum  = $signed({{17{osel[31]}}, osel}) + $signed(dsh[48:0]);

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      rs[j] = nneg[j] ? -$signed({3'b000, nmag[j][19:0]}) : $signed({3'b000, nmag[j][19:0]});
    end
  end
  assign ssum = rs[0] + rs[1] + rs[2];
  assign vt   = lvl | (8'd1 << cnt);

  assign done = state == SH_DONE;
  assign res  = '{hit: hit_r, hit_index: idx_r, hit_distance: hit_dist, intensity: lvl};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SH_IDLE;
    end else begin
      unique case (state)
        SH_IDLE: begin
          if (start) begin
            idx_r <= best.valid ? best.idx : '0;
            hit_r <= best.valid;
            ocq[0] <= best.ocx;
            ocq[1] <= best.ocy;
            ocq[2] <= best.ocz;
            cnt   <= '0;
            if (!best.valid) begin
              hit_dist <= DIST_MAX;
              lvl      <= bg_level;
              state    <= SH_DONE;
            end else begin
              hit_dist <= (|best.t[34:31]) ? DIST_MAX : best.t[30:0];
              state    <= SH_NMUL;
            end
          end
        end
        SH_NMUL: begin
          // normal part = oc + dir * distance, kept as sign and magnitude
          nneg[cnt[1:0]] <= nsum[48];
          nmag[cnt[1:0]] <= nsum[48] ? 48'(-nsum) : nsum[47:0];
          if (cnt == 3'd2) begin
            state <= SH_NORM;
          end
          cnt <= cnt + 3'd1;
        end
        SH_NORM: begin
          if ((|nmag[0][47:20]) || (|nmag[1][47:20]) || (|nmag[2][47:20])) begin
            for (int j = 0; j < 3; j++) begin
              nmag[j] <= nmag[j] >> 1;
            end
          end else begin
            state <= SH_SUM;
          end
        end
        SH_SUM: begin
          cnt  <= '0;
          len2 <= '0;
          spos <= ssum[21:0];
          if (ssum <= 0) begin
            lvl   <= '0;
            state <= SH_DONE;
          end else begin
            state <= SH_SQ;
          end
        end
        SH_SQ: begin
          priority case (cnt)
            3'd0, 3'd1, 3'd2: begin
              len2 <= len2 + ({22'd0, nmag[cnt[1:0]][19:0]} * {22'd0, nmag[cnt[1:0]][19:0]});
            end
            3'd3: ss <= spos * spos;
            default: begin
              rhs   <= 60'(ss) * 60'd65025;
              lhs   <= {1'b0, len2, 1'b0} + {2'b00, len2};
              lvl   <= '0;
              sub   <= '0;
              state <= SH_V;
            end
          endcase
          cnt <= (cnt == 3'd4) ? 3'd7 : cnt + 3'd1;
        end
        SH_V: begin
          // binary search for the largest level whose square fits
          unique case (sub)
            2'd0: begin
              vsq <= vt * vt;
              sub <= 2'd1;
            end
            2'd1: begin
              vprod <= 60'(vsq) * 60'(lhs);
              sub   <= 2'd2;
            end
            default: begin
              if (vprod <= rhs) begin
                lvl <= vt;
              end
              sub <= 2'd0;
              if (cnt == 3'd0) begin
                state <= SH_DONE;
              end
              cnt <= cnt - 3'd1;
            end
          endcase
        end
        default: begin
          state <= SH_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/ray_sphere_nearest_hit_shade.sv =====
`timescale 1ns / 1ps
`default_nettype none

// ray against sphere table, nearest hit with diffuse gray shading
// input channel (in_valid/in_ready/in_item) carries two kinds of item:
//   load item: writes one sphere into the table, gives no result
//   trace item: tests the first active_spheres entries, gives one result item
// output channel (out_valid/out_ready/out_item): hit flag, index, distance, level
// apb port: register 0 at address 0 is active_spheres, register 1 at address 4
//   is background_level; pready is always high
// one trace item at a time: a row of 16 sphere cells works in lockstep,
//   8 multiply steps on one multiplier per cell, a 32-step square root per cell,
//   then the best hit ripples down the row one cell per cycle
// the shading unit then goes straight to done on a miss, stops early with level 0
//   when the normal faces away from the light and otherwise runs a binary search
//   on the level, its normalize shift loop being the variable part; the next item
//   is taken once the trace item's result is in the output register
// reset clears the sequencer and the output valid flag, sets active_spheres to 0
//   and background_level to 25; sphere entries hold garbage until loaded
// when the receiver stalls, the result waits in the output register while the
//   block takes and runs the next item; that item then waits for the register

module ray_sphere_nearest_hit_shade (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  rsn_pkg::rsn_in_t  in_item,
  output logic              out_valid,
  input  logic              out_ready,
  output rsn_pkg::rsn_out_t out_item,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import rsn_pkg::*;

  localparam logic REG_ACTIVE = 1'b0;
  localparam logic REG_BG     = 1'b1;

  logic [3:0]       state;
  logic [4:0]       cnt;
  logic [4:0]       active_spheres;
  logic [7:0]       bg_level;
  logic [CNT_W-1:0] count;
  rsn_ray_t         ray;
  rsn_ctl_t         ctl;
  rsn_best_t        chain [MAX_SPHERES];
  rsn_best_t        prev  [MAX_SPHERES];
  logic             sh_start;
  logic             sh_done;
  rsn_out_t         sh_res;
  logic             in_acc;

  assign pready   = 1'b1;
  assign in_ready = state == ST_IDLE;
  assign in_acc   = in_valid && in_ready;

  // config register file
  always_ff @(posedge clk) begin
    if (rst) begin
      active_spheres <= '0;
      bg_level       <= 8'd25;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        REG_ACTIVE: active_spheres <= pwdata[4:0];
        REG_BG:     bg_level       <= pwdata[7:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_ACTIVE: prdata = {27'd0, active_spheres};
      REG_BG:     prdata = {24'd0, bg_level};
    endcase
  end

  // counts above the table size test the whole table
  assign count = (active_spheres > 5'(MAX_SPHERES)) ? CNT_W'(MAX_SPHERES)
                                                    : CNT_W'(active_spheres);

  assign ctl = '{ld_en: in_acc && !in_item.req_type, state: state,
                 msel: cnt[2:0], count: count};

  // sphere cells; the running best enters at cell 0 and leaves at the last
  assign prev[0] = '0;
  for (genvar i = 0; i < MAX_SPHERES; i++) begin : g_cell
    if (i > 0) begin : g_link
      assign prev[i] = chain[i-1];
    end
    rsn_cell u_cell (
      .clk      (clk),
      .cell_idx (IDX_W'(i)),
      .ctl      (ctl),
      .req      (in_item),
      .ray      (ray),
      .prev     (prev[i]),
      .best     (chain[i])
    );
  end

  rsn_shade u_shade (
    .clk      (clk),
    .rst      (rst),
    .start    (sh_start),
    .best     (chain[MAX_SPHERES-1]),
    .ray      (ray),
    .bg_level (bg_level),
    .done     (sh_done),
    .res      (sh_res)
  );

  // trace sequencer
  always_ff @(posedge clk) begin
    if (in_acc) begin
      ray <= '{ox: in_item.origin_x, oy: in_item.origin_y, oz: in_item.origin_z,
               dx: in_item.dir_x, dy: in_item.dir_y, dz: in_item.dir_z};
    end
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      sh_start  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // shading starts once the last cell holds the best hit
      sh_start <= state == ST_CHAIN && cnt == 5'(MAX_SPHERES - 1);
      // output register: load a finished result when free, else drain it
      if (state == ST_OUT && (!out_valid || out_ready)) begin
        out_item  <= sh_res;
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          cnt <= '0;
          if (in_acc && in_item.req_type) begin
            state <= ST_OC;
          end
        end
        ST_OC: state <= ST_MUL;
        ST_MUL: begin
          if (cnt == 5'd7) begin
            cnt   <= '0;
            state <= ST_DISC;
          end else begin
            cnt <= cnt + 5'd1;
          end
        end
        ST_DISC: state <= ST_SQRT;
        ST_SQRT: begin
          if (cnt == 5'd31) begin
            cnt   <= '0;
            state <= ST_ROOT;
          end else begin
            cnt <= cnt + 5'd1;
          end
        end
        ST_ROOT: state <= ST_CHAIN;
        ST_CHAIN: begin
          if (cnt == 5'(MAX_SPHERES - 1)) begin
            cnt   <= '0;
            state <= ST_SHADE;
          end else begin
            cnt <= cnt + 5'd1;
          end
        end
        ST_SHADE: begin
          if (sh_done) begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!out_valid || out_ready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // the shading unit only reports back while the sequencer waits for it
  a_done_in_shade: assert property (@(posedge clk) disable iff (rst)
    sh_done |-> state == ST_SHADE)
    else $error("shade done outside shade state");

  // a miss always carries index 0 and the saturated distance
  a_miss_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_item.hit |-> out_item.hit_index == '0 &&
      out_item.hit_distance == DIST_MAX)
    else $error("miss item with stray fields");

  // the best-hit ripple always starts right after the root step
  a_chain_entry: assert property (@(posedge clk) disable iff (rst)
    state == ST_CHAIN && cnt == '0 |-> $past(state) == ST_ROOT)
    else $error("chain entered out of order");

  // a new result is only loaded when the output register is free
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    state == ST_OUT && out_valid && !out_ready |=> state == ST_OUT)
    else $error("result register overwritten");

endmodule

`default_nettype wire
